>>> rtl/rws_pkg.sv
// Shared types and constants of the roulette wheel selector.
package rws_pkg;

  // Fixed widths of the payload fields.
  localparam int unsigned OP_W        = 1;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned SCORE_IN_W  = 16;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned TOTAL_OUT_W = 22;

  // Step counter of the shift-add multiply, one step per fraction bit.
  localparam int unsigned MUL_CNT_W   = $clog2(FRAC_W);

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SELECT = 1'b1;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

>>> rtl/rws_score_ram.sv
// Score table memory: one write port, one read port with registered data.
module rws_score_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rws_alu.sv
// Shared adder/subtractor used by the total update, the multiply and the walk.
module rws_alu #(
  parameter int unsigned WIDTH = 22
) (
  input  logic [WIDTH-1:0]      a_i,
  input  logic [WIDTH-1:0]      b_i,
  input  rws_pkg::alu_op_e      op_i,
  output logic [WIDTH:0]        y_o
);

  always_comb begin
    case (op_i)
      rws_pkg::ALU_ADD: y_o = {1'b0, a_i} + {1'b0, b_i};
      rws_pkg::ALU_SUB: y_o = {1'b0, a_i} - {1'b0, b_i};
      default:          y_o = {1'b0, a_i};
    endcase
  end

endmodule

>>> rtl/roulette_wheel_selector_top.sv
// Top level of the roulette wheel selector: sequencer, datapath and output register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | op, entry_index, score_value, rand_fraction
//   out     | output    | out_valid_o/out_ready_i| selected_index, total_score, was_select
//
// A write beat runs from accept to result through old score read, subtract, add and result;
// a write to an index out of range goes straight to result. A select beat takes 16 multiply
// steps, 1 to ENTRIES walk steps and a result step; it shares the single adder and the
// memory read port. After reset a clearing pass zeroes the table with in_ready_o low.
// A finished result waits in its state until the output register is free; the output
// register holds a beat under stall while the next input beat is already taken.
module roulette_wheel_selector_top #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned SCORE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rws_pkg::OP_W-1:0]          op_i,
  input  logic [rws_pkg::INDEX_W-1:0]       entry_index_i,
  input  logic [rws_pkg::SCORE_IN_W-1:0]    score_value_i,
  input  logic [rws_pkg::FRAC_W-1:0]        rand_fraction_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rws_pkg::INDEX_W-1:0]       selected_index_o,
  output logic [rws_pkg::TOTAL_OUT_W-1:0]   total_score_o,
  output logic                              was_select_o
);

  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned TOT_W     = SCORE_BITS + IDX_W;
  localparam int unsigned FRAC_W    = rws_pkg::FRAC_W;
  localparam int unsigned CNT_W     = rws_pkg::MUL_CNT_W;
  localparam int unsigned IDX_OUT_W = rws_pkg::INDEX_W;
  localparam int unsigned TOT_OUT_W = rws_pkg::TOTAL_OUT_W;
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(FRAC_W - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WR_SUB = 3'd2;
  localparam logic [2:0] S_WR_ADD = 3'd3;
  localparam logic [2:0] S_MULT   = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TOT_W-1:0]      total_q, total_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  is_sel_q, is_sel_d;
  logic                  out_valid_q, out_valid_d;
  logic [TOT_W-1:0]      acc_q, acc_d;
  logic [TOT_W-1:0]      hi_q, hi_d;
  logic [FRAC_W-1:0]     lo_q, lo_d;
  logic [SCORE_BITS-1:0] val_q, val_d;
  logic                  out_load;

  logic [IDX_OUT_W-1:0]  out_sel_q;
  logic [TOT_OUT_W-1:0]  out_total_q;
  logic                  out_is_sel_q;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SCORE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [SCORE_BITS-1:0] ram_rdata;

  logic [TOT_W-1:0]      alu_a;
  logic [TOT_W-1:0]      alu_b;
  rws_pkg::alu_op_e      alu_op;
  logic [TOT_W:0]        alu_y;
  logic [TOT_W:0]        mul_y;
  logic                  in_range;

  assign in_range = 32'(entry_index_i) < 32'(ENTRIES);

  rws_score_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .DATA_W (SCORE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rws_alu #(
    .WIDTH (TOT_W)
  ) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .op_i (alu_op),
    .y_o  (alu_y)
  );

  // A multiply step adds the total only when the current fraction bit is set.
  assign mul_y = lo_q[0] ? alu_y : {1'b0, hi_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    is_sel_d    = is_sel_q;
    acc_d       = acc_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = val_q;
    ram_raddr   = idx_q;
    alu_a       = total_q;
    alu_b       = TOT_W'(ram_rdata);
    alu_op      = rws_pkg::ALU_ADD;
    in_ready_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        total_d   = '0;
        if (idx_q == LAST) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = IDX_W'(entry_index_i);
        if (in_valid_i) begin
          is_sel_d = (op_i == rws_pkg::OP_SELECT);
          if (op_i == rws_pkg::OP_SELECT) begin
            lo_d    = rand_fraction_i;
            hi_d    = '0;
            acc_d   = '0;
            idx_d   = '0;
            cnt_d   = '0;
            state_d = S_MULT;
          end else if (in_range) begin
            idx_d   = IDX_W'(entry_index_i);
            val_d   = SCORE_BITS'(score_value_i);
            state_d = S_WR_SUB;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_WR_SUB: begin
        alu_op  = rws_pkg::ALU_SUB;
        total_d = alu_y[TOT_W-1:0];
        state_d = S_WR_ADD;
      end
      S_WR_ADD: begin
        alu_b   = TOT_W'(val_q);
        total_d = alu_y[TOT_W-1:0];
        ram_we  = 1'b1;
        state_d = S_RESULT;
      end
      S_MULT: begin
        // Entry 0 is fetched here so that the walk starts with its score in hand.
        ram_raddr = '0;
        alu_a     = hi_q;
        alu_b     = total_q;
        hi_d      = mul_y[TOT_W:1];
        lo_d      = {mul_y[0], lo_q[FRAC_W-1:1]};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_END) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // acc_q holds the sum of the entries before idx_q; hi_q holds the pick point.
        alu_a     = acc_q;
        ram_raddr = (idx_q == LAST) ? idx_q : idx_q + 1'b1;
        if ((alu_y >= {1'b0, hi_q}) || (idx_q == LAST)) begin
          state_d = S_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
          acc_d = alu_y[TOT_W-1:0];
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      is_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      is_sel_q    <= is_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    val_q <= val_d;
    if (out_load) begin
      out_sel_q    <= is_sel_q ? IDX_OUT_W'(idx_q) : '0;
      out_total_q  <= TOT_OUT_W'(total_q);
      out_is_sel_q <= is_sel_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = out_sel_q;
  assign total_score_o    = out_total_q;
  assign was_select_o     = out_is_sel_q;

  // The table is written only by the clearing pass and the second step of a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_CLEAR) || (state_q == S_WR_ADD)))
    else $error("score table written outside clear or write step");

  // A prefix of the table can never exceed the running total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (acc_q <= total_q))
    else $error("walk prefix sum exceeds total");

  // The pick point produced by the multiply lies within the total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) && $past(state_q == S_MULT)) |-> (hi_q <= total_q))
    else $error("pick point exceeds total");

  // A result is only loaded while the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending output beat");

endmodule
